// ----- hdl/eds_pkg.sv -----
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types and fixed constants of the elevator disk request scheduler.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam int ADDR_W              = 15;
  localparam int TAG_W               = 8;
  localparam int CYL_W               = 8;
  localparam int TRK_W               = 5;
  localparam int REC_W               = 3;
  localparam int RECORDS_PER_TRACK   = 8;
  localparam int TRACKS_PER_CYLINDER = 20;
  localparam int CYLINDER_COUNT      = 200;
  localparam int CYL_STRIDE          = RECORDS_PER_TRACK * TRACKS_PER_CYLINDER;
  localparam int RESET_START_ADDRESS = 600;

  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_START_UP      = 1'b1;

  typedef enum logic [1:0] {
    STAT_ACCEPTED,
    STAT_REJECTED,
    STAT_DISPATCHED,
    STAT_EMPTY
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUBMIT,
    S_SCAN,
    S_TAIL,
    S_PICK,
    S_FINISH
  } state_e;

endpackage

// ----- hdl/eds_ram.sv -----
// ----------------------------------------------------------------------------
// eds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/elevator_disk_request_scheduler.sv -----
// ----------------------------------------------------------------------------
// elevator_disk_request_scheduler
// LOOK elevator scheduler over a table of pending disk requests.
//
// Input words (mode, cylinder, track, record, request_tag) arrive on a
// valid/ready channel; each gives exactly one result word on the output
// valid/ready channel. A submit stores the request in the lowest free slot;
// a dispatch serves the nearest pending address in the sweep direction,
// flipping the sweep when nothing lies ahead.
// The block takes one word at a time and is not ready while it works.
// A submit walks the valid bits one slot a cycle until a free slot or the
// last slot. A dispatch streams the request RAM through one compare unit,
// one slot a cycle, then passes a tail step for the read data and a pick
// step; the scan runs again when the sweep flips, and an empty table
// answers without a scan. The result sits in an output register, so a
// stalled receiver only holds the next word's finish step until it is taken.
// Reset clears the table at once through per-slot valid bits, loads the head
// with 600 and sweeps upward. The start registers sit on an APB port at byte
// addresses 0 and 4; writing one reloads the head or the sweep direction.
// ----------------------------------------------------------------------------
module elevator_disk_request_scheduler
  import eds_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [CYL_W-1:0]                 cylinder_i,
  input  logic [TRK_W-1:0]                 track_i,
  input  logic [REC_W-1:0]                 record_i,
  input  logic [TAG_W-1:0]                 request_tag_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [ADDR_W-1:0]                served_address_o,
  output logic [TAG_W-1:0]                 served_tag_o,
  output logic                             moving_up_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count_o
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = ADDR_W + TAG_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  state_e state_q, state_d;

  logic [CYL_W-1:0]       cyl_q;
  logic [TRK_W-1:0]       trk_q;
  logic [REC_W-1:0]       rec_q;
  logic [TAG_W-1:0]       tag_q;
  logic [IW-1:0]          idx_q;
  logic [IW-1:0]          cmp_idx_q;
  logic                   chk_q;
  logic                   flipped_q;
  logic                   best_found_q;
  logic [ADDR_W-1:0]      best_addr_q;
  logic [TAG_W-1:0]       best_tag_q;
  logic [IW-1:0]          best_idx_q;
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [CW-1:0]          pending_q;
  logic [ADDR_W-1:0]      head_q;
  logic                   sweep_q;
  logic [ADDR_W-1:0]      start_addr_q;
  logic                   start_up_q;
  status_e                res_status_q, res_status_d;
  logic [ADDR_W-1:0]      res_addr_q;
  logic [TAG_W-1:0]       res_tag_q;
  status_e                out_status_q;
  logic [ADDR_W-1:0]      out_addr_q;
  logic [TAG_W-1:0]       out_tag_q;
  logic                   out_up_q;
  logic [CW-1:0]          out_count_q;
  logic                   out_valid_q;

  logic              capture, sub_write, serve, flip, scan_start, idx_inc;
  logic              res_load, out_load, range_ok, cfg_wr, hit;
  logic [31:0]       lin_full;
  logic [ADDR_W-1:0] lin_addr, cand_addr;
  logic [TAG_W-1:0]  cand_tag;
  logic [RW-1:0]     rd_data;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_UP) ? 32'(start_up_q) : 32'(start_addr_q);

  assign lin_full = 32'(rec_q) + 32'(RECORDS_PER_TRACK) * 32'(trk_q)
                  + 32'(CYL_STRIDE) * 32'(cyl_q);
  assign lin_addr = lin_full[ADDR_W-1:0];
  assign range_ok = (32'(cyl_q) < 32'(CYLINDER_COUNT)) &&
                    (32'(trk_q) < 32'(TRACKS_PER_CYLINDER)) &&
                    (32'(rec_q) < 32'(RECORDS_PER_TRACK));

  eds_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (sub_write),
    .waddr_i (idx_q),
    .wdata_i ({tag_q, lin_addr}),
    .re_i    (state_q == S_SCAN),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // shared compare unit: one candidate slot a cycle
  assign cand_addr = rd_data[ADDR_W-1:0];
  assign cand_tag  = rd_data[RW-1:ADDR_W];
  always_comb begin
    hit = 1'b0;
    if (chk_q && valid_q[cmp_idx_q]) begin
      if (sweep_q) begin
        hit = (cand_addr >= head_q) && (!best_found_q || (cand_addr < best_addr_q));
      end else begin
        hit = (cand_addr <= head_q) && (!best_found_q || (cand_addr > best_addr_q));
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    capture      = 1'b0;
    sub_write    = 1'b0;
    serve        = 1'b0;
    flip         = 1'b0;
    scan_start   = 1'b0;
    idx_inc      = 1'b0;
    res_load     = 1'b0;
    res_status_d = STAT_EMPTY;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          capture = 1'b1;
          if (!mode_i) begin
            state_d = S_SUBMIT;
          end else if (pending_q == '0) begin
            res_load     = 1'b1;
            res_status_d = STAT_EMPTY;
            state_d      = S_FINISH;
          end else begin
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end
        end
      end
      S_SUBMIT: begin
        if (!range_ok) begin
          res_load     = 1'b1;
          res_status_d = STAT_REJECTED;
          state_d      = S_FINISH;
        end else if (!valid_q[idx_q]) begin
          sub_write    = 1'b1;
          res_load     = 1'b1;
          res_status_d = STAT_ACCEPTED;
          state_d      = S_FINISH;
        end else if (idx_q == LAST_IDX) begin
          res_load     = 1'b1;
          res_status_d = STAT_REJECTED;
          state_d      = S_FINISH;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        idx_inc = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (best_found_q) begin
          serve        = 1'b1;
          res_load     = 1'b1;
          res_status_d = STAT_DISPATCHED;
          state_d      = S_FINISH;
        end else if (!flipped_q) begin
          flip       = 1'b1;
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end else begin
          res_load     = 1'b1;
          res_status_d = STAT_EMPTY;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      pending_q    <= '0;
      head_q       <= ADDR_W'(RESET_START_ADDRESS);
      sweep_q      <= 1'b1;
      start_addr_q <= ADDR_W'(RESET_START_ADDRESS);
      start_up_q   <= 1'b1;
      out_valid_q  <= 1'b0;
      chk_q        <= 1'b0;
      best_found_q <= 1'b0;
      flipped_q    <= 1'b0;
    end else begin
      chk_q <= (state_q == S_SCAN);
      if (cfg_wr) begin
        if (paddr[2] == REG_START_ADDRESS) begin
          start_addr_q <= pwdata[ADDR_W-1:0];
          head_q       <= pwdata[ADDR_W-1:0];
        end else begin
          start_up_q <= pwdata[0];
          sweep_q    <= pwdata[0];
        end
      end
      if (sub_write) begin
        valid_q[idx_q] <= 1'b1;
        pending_q      <= pending_q + CW'(1);
      end
      if (serve) begin
        valid_q[best_idx_q] <= 1'b0;
        pending_q           <= pending_q - CW'(1);
        head_q              <= best_addr_q;
      end
      if (flip) begin
        sweep_q <= !sweep_q;
      end
      if (capture) begin
        flipped_q <= 1'b0;
      end else if (flip) begin
        flipped_q <= 1'b1;
      end
      if (scan_start) begin
        best_found_q <= 1'b0;
      end else if (hit) begin
        best_found_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (capture) begin
      cyl_q  <= cylinder_i;
      trk_q  <= track_i;
      rec_q  <= record_i;
      tag_q  <= request_tag_i;
    end
    if (capture || scan_start) begin
      idx_q <= '0;
    end else if (idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
    if (hit) begin
      best_addr_q <= cand_addr;
      best_tag_q  <= cand_tag;
      best_idx_q  <= cmp_idx_q;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_addr_q   <= serve ? best_addr_q : '0;
      res_tag_q    <= serve ? best_tag_q : '0;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_tag_q    <= res_tag_q;
      out_up_q     <= sweep_q;
      out_count_q  <= pending_q;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign served_address_o = out_addr_q;
  assign served_tag_o     = out_tag_q;
  assign moving_up_o      = out_up_q;
  assign pending_count_o  = out_count_q;

endmodule

// ----- hdl/eds_checker.sv -----
// ----------------------------------------------------------------------------
// eds_checker
// Port-level checks of the scheduler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module eds_checker
  import eds_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [1:0]                       status_o,
  input logic [ADDR_W-1:0]                served_address_o,
  input logic [TAG_W-1:0]                 served_tag_o,
  input logic                             moving_up_o,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(served_address_o) && $stable(served_tag_o) &&
    $stable(moving_up_o) && $stable(pending_count_o))
    else $error("result word changed while stalled");

  // only a dispatch carries an address and a tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_DISPATCHED) |->
    (served_address_o == '0) && (served_tag_o == '0))
    else $error("served fields nonzero without dispatch");

  // nothing pending means the table is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_EMPTY) |-> (pending_count_o == '0))
    else $error("nothing pending reported with requests in table");

  // pending count stays within the table, and a dispatch frees a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_count_o <= CW'(QUEUE_DEPTH)) &&
    ((status_o != STAT_DISPATCHED) || (pending_count_o < CW'(QUEUE_DEPTH))))
    else $error("pending count out of range");

endmodule

bind elevator_disk_request_scheduler eds_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_eds_checker (.*);

// ----- tb/tb_elevator_disk_request_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevator_disk_request_scheduler
// Self-checking bench for the LOOK elevator disk request scheduler.
//
// Submit and dispatch words go in on the input channel. A scoreboard keeps
// its own request table, head and sweep direction and works out the result
// word of every accepted input word. Each result word is compared field by
// field with the oldest prediction. Directed cases cover field limits, a
// rejected submit, a full table, equal addresses, direction flips and an
// empty table. Random traffic then runs in several phases. Each phase starts
// from a new head and direction set through the APB port, and has its own
// sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_elevator_disk_request_scheduler;
  import eds_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 16;

  localparam logic MODE_SUBMIT   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  localparam logic [2:0] PADDR_START_ADDRESS = {REG_START_ADDRESS, 2'b00};
  localparam logic [2:0] PADDR_START_UP      = {REG_START_UP, 2'b00};

  typedef struct packed {
    status_e              status;
    logic [ADDR_W-1:0]    addr;
    logic [TAG_W-1:0]     tag;
    logic                 up;
    logic [COUNT_W-1:0]   count;
  } sched_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [2:0]           paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i        = MODE_SUBMIT;
  logic [CYL_W-1:0]     cylinder_i    = '0;
  logic [TRK_W-1:0]     track_i       = '0;
  logic [REC_W-1:0]     record_i      = '0;
  logic [TAG_W-1:0]     request_tag_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [1:0]           status_o;
  logic [ADDR_W-1:0]    served_address_o;
  logic [TAG_W-1:0]     served_tag_o;
  logic                 moving_up_o;
  logic [COUNT_W-1:0]   pending_count_o;

  // scoreboard copy of the scheduler state
  logic                 tbl_valid [QUEUE_DEPTH];
  logic [ADDR_W-1:0]    tbl_addr  [QUEUE_DEPTH];
  logic [TAG_W-1:0]     tbl_tag   [QUEUE_DEPTH];
  logic [ADDR_W-1:0]    head_pos  = ADDR_W'(RESET_START_ADDRESS);
  logic                 sweep_asc = 1'b1;
  int                   tbl_count = 0;

  sched_result_t        due_results [$];
  int                   fail_count     = 0;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;

  elevator_disk_request_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .cylinder_i       (cylinder_i),
    .track_i          (track_i),
    .record_i         (record_i),
    .request_tag_i    (request_tag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .served_address_o (served_address_o),
    .served_tag_o     (served_tag_o),
    .moving_up_o      (moving_up_o),
    .pending_count_o  (pending_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** elevator_disk_request_scheduler: FAILED **");
    $finish;
  end

  function automatic int nearest_slot(input logic asc);
    int best = QUEUE_DEPTH;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (asc) begin
          if (tbl_addr[i] >= head_pos && (best == QUEUE_DEPTH || tbl_addr[i] < tbl_addr[best]))
            best = i;
        end else begin
          if (tbl_addr[i] <= head_pos && (best == QUEUE_DEPTH || tbl_addr[i] > tbl_addr[best]))
            best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic sched_result_t schedule_word(input logic m, input logic [CYL_W-1:0] c,
                                                  input logic [TRK_W-1:0] t,
                                                  input logic [REC_W-1:0] r,
                                                  input logic [TAG_W-1:0] g);
    sched_result_t res;
    int slot;
    res.status = STAT_EMPTY;
    res.addr   = '0;
    res.tag    = '0;
    if (m == MODE_SUBMIT) begin
      slot = QUEUE_DEPTH;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) slot = i;
      end
      if (slot == QUEUE_DEPTH || c >= CYLINDER_COUNT || t >= TRACKS_PER_CYLINDER ||
          r >= RECORDS_PER_TRACK) begin
        res.status = STAT_REJECTED;
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_addr[slot]  = ADDR_W'(int'(r) + RECORDS_PER_TRACK * int'(t) + CYL_STRIDE * int'(c));
        tbl_tag[slot]   = g;
        tbl_count++;
        res.status = STAT_ACCEPTED;
      end
    end else if (tbl_count != 0) begin
      slot = nearest_slot(sweep_asc);
      if (slot == QUEUE_DEPTH) begin
        sweep_asc = !sweep_asc;
        slot = nearest_slot(sweep_asc);
      end
      if (slot != QUEUE_DEPTH) begin
        res.status      = STAT_DISPATCHED;
        res.addr        = tbl_addr[slot];
        res.tag         = tbl_tag[slot];
        head_pos        = tbl_addr[slot];
        tbl_valid[slot] = 1'b0;
        tbl_count--;
      end
    end
    res.up    = sweep_asc;
    res.count = COUNT_W'(tbl_count);
    return res;
  endfunction

  task automatic send_word(input logic m, input logic [CYL_W-1:0] c, input logic [TRK_W-1:0] t,
                           input logic [REC_W-1:0] r, input logic [TAG_W-1:0] g);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    cylinder_i    <= c;
    track_i       <= t;
    record_i      <= r;
    request_tag_i <= g;
    do @(posedge clk_i); while (!in_ready_o);
    due_results.insert(due_results.size(), schedule_word(m, c, t, r, g));
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers are only written once every result word has come back
  task automatic load_start(input logic [ADDR_W-1:0] addr, input logic up);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    apb_write(PADDR_START_ADDRESS, 32'(addr));
    head_pos = addr;
    apb_write(PADDR_START_UP, 32'(up));
    sweep_asc = up;
  endtask

  task automatic send_random_word(input int dispatch_pct);
    logic m;
    logic [CYL_W-1:0] c;
    logic [TRK_W-1:0] t;
    int roll;
    m    = ($urandom_range(99) < dispatch_pct) ? MODE_DISPATCH : MODE_SUBMIT;
    c    = CYL_W'($urandom);
    t    = TRK_W'($urandom);
    roll = $urandom_range(99);
    if (m == MODE_SUBMIT && roll >= 8) begin
      if (roll < 30) begin
        // clustered near the edges so addresses repeat
        c = $urandom_range(1) ? CYL_W'(CYLINDER_COUNT - 1 - $urandom_range(1))
                              : CYL_W'($urandom_range(1));
        t = $urandom_range(1) ? TRK_W'(TRACKS_PER_CYLINDER - 1) : TRK_W'($urandom_range(1));
      end else begin
        c = CYL_W'($urandom_range(CYLINDER_COUNT - 1));
        t = TRK_W'($urandom_range(TRACKS_PER_CYLINDER - 1));
      end
    end
    send_word(m, c, t, REC_W'($urandom), TAG_W'($urandom));
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_words
    sched_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: status %0d", status_o);
        fail_count++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (served_address_o !== want.addr) begin
          $error("served_address: expected %0d, actual %0d", want.addr, served_address_o);
          fail_count++;
        end
        if (served_tag_o !== want.tag) begin
          $error("served_tag: expected %0d, actual %0d", want.tag, served_tag_o);
          fail_count++;
        end
        if (moving_up_o !== want.up) begin
          $error("moving_up: expected %0d, actual %0d", want.up, moving_up_o);
          fail_count++;
        end
        if (pending_count_o !== want.count) begin
          $error("pending_count: expected %0d, actual %0d", want.count, pending_count_o);
          fail_count++;
        end
      end
    end
  end

  // reset config: head 600 moving up
  task automatic test_limits_and_flip();
    send_word(MODE_DISPATCH, '0, '0, '0, '0);
    send_word(MODE_SUBMIT, 8'd0, 5'd0, 3'd0, 8'd0);
    send_word(MODE_SUBMIT, 8'd199, 5'd19, 3'd7, 8'd255);
    send_word(MODE_SUBMIT, 8'd200, 5'd0, 3'd0, 8'd17);
    send_word(MODE_SUBMIT, 8'd255, 5'd31, 3'd7, 8'haa);
    send_word(MODE_SUBMIT, 8'd0, 5'd20, 3'd0, 8'h55);
    send_word(MODE_DISPATCH, '0, '0, '0, '0);
    send_word(MODE_DISPATCH, 8'hff, 5'h1f, 3'h7, 8'hff);
    send_word(MODE_DISPATCH, '0, '0, '0, '0);
  endtask

  task automatic test_full_table_and_ties();
    load_start(ADDR_W'(RESET_START_ADDRESS), 1'b1);
    send_word(MODE_SUBMIT, 8'd3, 5'd15, 3'd0, 8'd1);
    send_word(MODE_SUBMIT, 8'd3, 5'd15, 3'd0, 8'd2);
    send_word(MODE_SUBMIT, 8'd3, 5'd14, 3'd7, 8'd3);
    for (int k = 3; k < QUEUE_DEPTH; k++) begin
      send_word(MODE_SUBMIT, CYL_W'($urandom_range(2)), TRK_W'($urandom_range(19)),
                REC_W'($urandom), TAG_W'($urandom));
    end
    send_word(MODE_SUBMIT, 8'd5, 5'd5, 3'd5, 8'd99);
    repeat (3) send_word(MODE_DISPATCH, '0, '0, '0, '0);
  endtask

  task automatic test_random_traffic(input int n_words, input int idle_in, input int stall_out,
                                     input logic [ADDR_W-1:0] start_addr, input logic start_up);
    int dispatch_pct;
    load_start(start_addr, start_up);
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    dispatch_pct   = 30;
    // alternate filling and draining bursts
    for (int k = 0; k < n_words; k++) begin
      if (k % 40 == 39) dispatch_pct = (dispatch_pct == 30) ? 65 : 30;
      send_random_word(dispatch_pct);
    end
  endtask

  initial begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_tag[i]   = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_limits_and_flip();
    test_full_table_and_ties();
    test_random_traffic(285, 0, 0, ADDR_W'(0), 1'b0);
    test_random_traffic(285, 87, 0, ADDR_W'(31999), 1'b1);
    test_random_traffic(285, 0, 87, ADDR_W'($urandom_range(31999)), 1'($urandom));
    test_random_traffic(285, 11, 11, ADDR_W'(RESET_START_ADDRESS), 1'b1);

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** elevator_disk_request_scheduler: PASSED **");
    end else begin
      $display("** elevator_disk_request_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
